>>> hdl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search package
// Shared constants, register indexes and the types passed between modules.
// ----------------------------------------------------------------------------
package mbps_pkg;

  // Longest pattern and the number of compare cells in the row.
  localparam int MAX_PATTERN = 16;
  localparam int CELL_IDX_W  = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 5;

  // Byte counter width; it saturates at its maximum.
  localparam int COUNT_W = 33;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Result queue between the compare row and the output.
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASE_ADDRESS   = 3'd0,
    REG_SEARCH_LENGTH  = 3'd1,
    REG_PATTERN_LOW    = 3'd2,
    REG_PATTERN_HIGH   = 3'd3,
    REG_COMPARE_MASK   = 3'd4,
    REG_PATTERN_LENGTH = 3'd5
  } mbps_reg_t;

  // Pattern settings seen by every compare cell.
  typedef struct packed {
    logic [MAX_PATTERN-1:0][7:0] pattern;
    logic [MAX_PATTERN-1:0]      mask;
    logic [LEN_W-1:0]            len;
  } mbps_match_cfg_t;

  // One queued result: the start offset is zero when nothing was found.
  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] start;
  } mbps_result_t;

endpackage

>>> hdl/mbps_if.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search channels
// Valid/ready channels for the byte stream and for search results.
// ----------------------------------------------------------------------------
interface mbps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface mbps_result_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [63:0] match_address;

  modport source (output valid, found, match_address, input ready);
  modport sink   (input valid, found, match_address, output ready);
endinterface

>>> hdl/mbps_cell.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search compare cell
// Holds one byte of the history window, passes it on to its neighbor and
// checks the byte at its distance against the pattern byte it stands for.
// ----------------------------------------------------------------------------
module mbps_cell
  import mbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  shift,
  input  logic [CELL_IDX_W-1:0] cell_index,
  input  mbps_match_cfg_t       cfg,
  input  logic [7:0]            byte_in,
  output logic [7:0]            byte_out,
  output logic                  ok
);

  logic [7:0]            held;
  logic                  in_use;
  logic [CELL_IDX_W-1:0] pat_idx;

  // Window byte moves one cell along with every accepted beat.
  always_ff @(posedge clk) begin
    if (shift) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;

  // The cell at distance d checks pattern byte len-1-d when d is below len.
  assign in_use  = {1'b0, cell_index} < cfg.len;
  assign pat_idx = CELL_IDX_W'(cfg.len - LEN_W'(1) - {1'b0, cell_index});
  assign ok      = !in_use || !cfg.mask[pat_idx] || (byte_in == cfg.pattern[pat_idx]);

endmodule

>>> hdl/mbps_result_queue.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search result queue
// Two-entry queue that lets the byte stream keep flowing while a result
// waits to be taken.
// ----------------------------------------------------------------------------
module mbps_result_queue
  import mbps_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  mbps_result_t push_entry,
  output logic         full,
  output logic         out_valid,
  input  logic         out_ready,
  output mbps_result_t out_entry
);

  mbps_result_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [FILL_W-1:0]       fill;
  logic                    pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = fill != '0;
  assign full      = fill == FILL_W'(QUEUE_DEPTH);
  assign out_entry = entries[rd_ptr];

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

>>> hdl/masked_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search
// A result is written into the result queue and offered from there. Throughput:
// one byte per cycle while the result queue is not full; the row of 16 compare
// cells checks the whole window in parallel and the start-offset compare closes
// in that cycle. Reset clears the configuration, the byte counter, the match
// flag and the result queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search
  import mbps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  mbps_byte_if.sink              byte_in,
  mbps_result_if.source          result_out
);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration registers.
  logic [63:0]            base_address;
  logic [31:0]            search_length;
  logic [63:0]            pattern_low;
  logic [63:0]            pattern_high;
  logic [MAX_PATTERN-1:0] compare_mask;
  logic [LEN_W-1:0]       pattern_length;

  // Scan state.
  logic [COUNT_W-1:0]     byte_count;
  logic                   match_reported;

  mbps_match_cfg_t        match_cfg;
  logic [LEN_W-1:0]       len_eff;
  logic                   in_accept;
  logic                   queue_full;
  logic [7:0]             chain [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_ok;
  logic [COUNT_W-1:0]     len_less_one;
  logic [COUNT_W-1:0]     start;
  logic                   hit;
  logic                   push;
  mbps_result_t           push_entry;
  mbps_result_t           out_entry;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address   <= '0;
      search_length  <= '0;
      pattern_low    <= '0;
      pattern_high   <= '0;
      compare_mask   <= '0;
      pattern_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_ADDRESS:   base_address   <= cfg_data;
        REG_SEARCH_LENGTH:  search_length  <= cfg_data[31:0];
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_COMPARE_MASK:   compare_mask   <= cfg_data[MAX_PATTERN-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A length above the cell count is taken as the full pattern.
  assign len_eff = (pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                          : pattern_length;

  assign match_cfg.pattern = {pattern_high, pattern_low};
  assign match_cfg.mask    = compare_mask;
  assign match_cfg.len     = len_eff;

  assign in_accept     = byte_in.valid && byte_in.ready;
  assign byte_in.ready = !queue_full;

  // Row of compare cells; cell d sees the byte d beats old.
  assign chain[0] = byte_in.data_byte;

  for (genvar d = 0; d < MAX_PATTERN; d++) begin : g_cell
    if (d < MAX_PATTERN - 1) begin : g_mid
      mbps_cell u_cell (
        .clk        (clk),
        .shift      (in_accept),
        .cell_index (CELL_IDX_W'(d)),
        .cfg        (match_cfg),
        .byte_in    (chain[d]),
        .byte_out   (chain[d+1]),
        .ok         (cell_ok[d])
      );
    end else begin : g_end
      mbps_cell u_cell (
        .clk        (clk),
        .shift      (in_accept),
        .cell_index (CELL_IDX_W'(d)),
        .cfg        (match_cfg),
        .byte_in    (chain[d]),
        .byte_out   (),
        .ok         (cell_ok[d])
      );
    end
  end

  // Match decision: an empty pattern matches at the first byte only, and only when the search length is nonzero.
  assign len_less_one = COUNT_W'(len_eff) - COUNT_W'(1);
  assign start        = (len_eff == '0) ? '0 : byte_count - len_less_one;

  always_comb begin
    hit = 1'b0;
    if (!match_reported) begin
      if (len_eff == '0) begin
        hit = (byte_count == '0) && (search_length != '0);
      end else begin
        hit = (byte_count >= len_less_one) &&
              (start < COUNT_W'(search_length)) &&
              (&cell_ok);
      end
    end
  end

  // A result is queued on a match, or at the end of a scan with no match.
  assign push             = in_accept && (hit || (byte_in.last_byte && !match_reported));
  assign push_entry.found = hit;
  assign push_entry.start = hit ? start : '0;

  // Scan counter and match flag; the last byte starts a new scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      match_reported <= 1'b0;
    end else if (in_accept) begin
      if (byte_in.last_byte) begin
        byte_count     <= '0;
        match_reported <= 1'b0;
      end else begin
        if (byte_count != COUNT_MAX) begin
          byte_count <= byte_count + COUNT_W'(1);
        end
        match_reported <= match_reported || hit;
      end
    end
  end

  mbps_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_entry  (out_entry)
  );

  // The address is formed from the queued offset as the beat leaves.
  assign result_out.found         = out_entry.found;
  assign result_out.match_address = out_entry.found ? base_address + 64'(out_entry.start)
                                                    : '0;

  // A last byte always opens a fresh scan.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && byte_in.last_byte |=> (byte_count == '0) && !match_reported)
    else $error("scan state not cleared after last byte");

  // The counter advances by one on every inner byte until it saturates.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    in_accept && !byte_in.last_byte && (byte_count != COUNT_MAX)
    |=> byte_count == $past(byte_count) + COUNT_W'(1))
    else $error("byte counter did not advance");

  // A no-match result carries a zero address.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && !result_out.found |-> result_out.match_address == '0)
    else $error("no-match result with nonzero address");

endmodule

>>> tb/tb_masked_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search testbench
// Streams byte beats through the search block and compares every result beat
// with a cycle-free model of the scan kept in the bench. A short table of
// hand-checked scans comes first: reset values, the empty pattern, a full
// 16-byte pattern, a match cut off by the end of the region and the start
// offset limit. Random scans follow, most with the pattern planted in them.
// Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_masked_byte_pattern_search
  import mbps_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1350;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

  typedef struct packed {
    logic        found;
    logic [63:0] match_address;
  } search_result_t;

  typedef enum bit {ROW_WRITE, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t      kind;
    mbps_reg_t      index;
    logic [63:0]    value;
    logic [7:0]     data;
    bit             last;
    bit             exp_n;
    search_result_t exp;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  mbps_byte_if   byte_ch ();
  mbps_result_if result_ch ();

  masked_byte_pattern_search u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_in    (byte_ch),
    .result_out (result_ch)
  );

  // Register copies and scan state of the bench model.
  logic [63:0]        cur_base = '0;
  logic [31:0]        cur_slen = '0;
  logic [63:0]        cur_pat_lo = '0;
  logic [63:0]        cur_pat_hi = '0;
  logic [15:0]        cur_mask = '0;
  logic [4:0]         cur_len = '0;
  logic [7:0]         scan_window [0:MAX_PATTERN-2];
  logic [COUNT_W-1:0] scan_count = '0;
  bit                 scan_matched = 0;

  search_result_t expected_results [$];
  stim_row_t      directed_rows [$];
  int             mismatch_count = 0;
  int             random_beats = 0;

  // Hand-typed expectation that travels with the current byte beat.
  bit             row_typed = 0;
  bit             row_exp_n = 0;
  search_result_t row_exp = '0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // Most stalls are zero or short, a few are long; calm stretches have none.
  function automatic int pick_stall(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void clear_scan();
    foreach (scan_window[i]) scan_window[i] = '0;
    scan_count   = '0;
    scan_matched = 0;
  endfunction

  // One byte of the scan: decides whether this byte ends a match or the region.
  function automatic void predict_scan_step(input logic [7:0] b, input bit last,
                                            output bit produced,
                                            output search_result_t res);
    int                 len;
    logic [COUNT_W-1:0] start;
    logic [127:0]       pat;
    logic [7:0]         seen;
    bit                 hit;
    bit                 ok;
    produced = 0;
    res      = '0;
    hit      = 0;
    ok       = 0;
    start    = '0;
    pat      = {cur_pat_hi, cur_pat_lo};
    len      = (cur_len > MAX_PATTERN) ? MAX_PATTERN : int'(cur_len);

    if (!scan_matched) begin
      if (len == 0) begin
        hit = (scan_count == '0) && (cur_slen != '0);
      end else if (scan_count >= COUNT_W'(len - 1)) begin
        start = scan_count - COUNT_W'(len - 1);
        if (start < {1'b0, cur_slen}) begin
          ok = 1;
          for (int k = 0; k < len; k++) begin
            seen = (k == len - 1) ? b : scan_window[len - 2 - k];
            if (cur_mask[k] && seen != pat[8*k +: 8]) ok = 0;
          end
          hit = ok;
        end
      end
    end

    if (hit) begin
      produced          = 1;
      res.found         = 1'b1;
      res.match_address = cur_base + 64'(start);
      scan_matched      = 1;
    end else if (last && !scan_matched) begin
      produced = 1;
    end

    if (last) begin
      clear_scan();
    end else begin
      for (int i = MAX_PATTERN - 2; i > 0; i--) scan_window[i] = scan_window[i - 1];
      scan_window[0] = b;
      if (scan_count != COUNT_LIMIT) scan_count = scan_count + 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Register writes, result checks and byte predictions, all at the rising edge.
  always @(posedge clk) begin : scoreboard
    bit             produced;
    search_result_t res;
    search_result_t want;
    if (rst) begin
      cur_base   <= '0;
      cur_slen   <= '0;
      cur_pat_lo <= '0;
      cur_pat_hi <= '0;
      cur_mask   <= '0;
      cur_len    <= '0;
      clear_scan();
      expected_results.delete();
    end else begin
      if (cfg_write === 1'b1) begin
        case (cfg_index)
          REG_BASE_ADDRESS:   cur_base   = cfg_data;
          REG_SEARCH_LENGTH:  cur_slen   = cfg_data[31:0];
          REG_PATTERN_LOW:    cur_pat_lo = cfg_data;
          REG_PATTERN_HIGH:   cur_pat_hi = cfg_data;
          REG_COMPARE_MASK:   cur_mask   = cfg_data[15:0];
          REG_PATTERN_LENGTH: cur_len    = cfg_data[4:0];
          default: ;
        endcase
      end

      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: found=%0b addr=%h",
                                    result_ch.found, result_ch.match_address));
        end else begin
          want = expected_results.pop_front();
          if (result_ch.found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b",
                                      result_ch.found, want.found));
          if (result_ch.match_address !== want.match_address)
            report_mismatch($sformatf("match_address %h, expected %h",
                                      result_ch.match_address, want.match_address));
        end
      end

      if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) begin
        predict_scan_step(byte_ch.data_byte, byte_ch.last_byte, produced, res);
        if (row_typed) begin
          if (row_exp_n) expected_results.push_back(row_exp);
        end else if (produced) begin
          expected_results.push_back(res);
        end
      end
    end
  end

  // Result side: ready drops at random, with calm stretches in between.
  initial begin : result_sink
    int hold;
    int phase_left;
    bit calm;
    hold            = 0;
    phase_left      = 100;
    calm            = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        calm       = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(64, 300);
      end else begin
        phase_left--;
      end
      if (hold > 0) begin
        result_ch.ready <= 1'b0;
        hold--;
      end else begin
        hold = pick_stall(calm);
        result_ch.ready <= (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  task automatic write_reg(input mbps_reg_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic cfg_done();
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Hold the byte side until every expected result has come out.
  task automatic wait_idle();
    @(negedge clk);
    byte_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_beat(input logic [7:0] b, input bit last, input bit typed,
                           input bit exp_n, input search_result_t exp, input bit calm);
    repeat (pick_stall(calm)) begin
      @(negedge clk);
      byte_ch.valid <= 1'b0;
    end
    @(negedge clk);
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    row_typed         <= typed;
    row_exp_n         <= exp_n;
    row_exp           <= exp;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
  endtask

  // Random register settings, extremes included; junk above each field width.
  task automatic pick_settings(input bit all);
    int          r;
    logic [63:0] v;
    if (all || $urandom_range(0, 1)) begin
      r = $urandom_range(0, 9);
      if (r == 0) v = '0;
      else if (r < 3) v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
      else v = rand64();
      write_reg(REG_BASE_ADDRESS, v);
    end
    if (all || $urandom_range(0, 1)) begin
      r = $urandom_range(0, 9);
      if (r < 5) v = {$urandom, 32'($urandom_range(0, 40))};
      else if (r < 7) v = {$urandom, 32'hFFFF_FFFF};
      else if (r == 7) v = {$urandom, 32'h0};
      else v = rand64();
      write_reg(REG_SEARCH_LENGTH, v);
    end
    if (all || $urandom_range(0, 1)) write_reg(REG_PATTERN_LOW, rand64());
    if (all || $urandom_range(0, 1)) write_reg(REG_PATTERN_HIGH, rand64());
    if (all || $urandom_range(0, 1)) begin
      r = $urandom_range(0, 9);
      if (r == 0) v = {rand64()} & ~64'hFFFF;
      else if (r < 3) v = rand64() | 64'hFFFF;
      else if (r < 6) v = rand64();
      else v = rand64() | 64'($urandom);
      write_reg(REG_COMPARE_MASK, v);
    end
    if (all || $urandom_range(0, 1)) begin
      r = $urandom_range(0, 9);
      v = rand64() & ~64'h1F;
      if (r == 0) v[4:0] = 5'd0;
      else if (r == 1) v[4:0] = 5'($urandom_range(17, 31));
      else if (r < 4) v[4:0] = 5'($urandom_range(9, 16));
      else v[4:0] = 5'($urandom_range(1, 8));
      write_reg(REG_PATTERN_LENGTH, v);
    end
  endtask

  function automatic stim_row_t wr_row(input mbps_reg_t idx, input logic [63:0] value);
    stim_row_t row;
    row       = '{default: '0, kind: ROW_WRITE, index: idx, exp: '0};
    row.value = value;
    return row;
  endfunction

  function automatic stim_row_t beat_row(input logic [7:0] d, input bit last,
                                         input bit exp_n, input bit found,
                                         input logic [63:0] addr);
    stim_row_t row;
    row       = '{default: '0, kind: ROW_BEAT, index: REG_BASE_ADDRESS, exp: '0};
    row.data  = d;
    row.last  = last;
    row.exp_n = exp_n;
    row.exp   = '{found: found, match_address: addr};
    return row;
  endfunction

  initial begin : stimulus
    logic [7:0]   scan_bytes [0:63];
    logic [127:0] pat_all;
    int           n;
    int           p;
    int           eff;
    int           r;
    int           pick;
    int           flip;
    int           mid_at;
    bit           embed;
    bit           fill_mode;
    bit           calm;
    bit           first;
    bit           cfg_open;

    rst               = 1'b1;
    cfg_write         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: empty pattern but no start offsets, so the scan ends empty.
    directed_rows.push_back(beat_row(8'h00, 1, 1, 0, 64'd0));
    // Empty pattern with one start offset hits on the first byte; the end that
    // follows a reported match gives nothing.
    directed_rows.push_back(wr_row(REG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_rows.push_back(wr_row(REG_SEARCH_LENGTH, 64'd1));
    directed_rows.push_back(beat_row(8'hFF, 0, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_rows.push_back(beat_row(8'h5A, 1, 0, 0, 64'd0));
    // Oversized length clamps to 16; the full match completes on the last byte.
    directed_rows.push_back(wr_row(REG_BASE_ADDRESS, 64'd0));
    directed_rows.push_back(wr_row(REG_SEARCH_LENGTH, 64'hFFFF_FFFF));
    directed_rows.push_back(wr_row(REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_rows.push_back(wr_row(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_rows.push_back(wr_row(REG_COMPARE_MASK, 64'hFFFF));
    directed_rows.push_back(wr_row(REG_PATTERN_LENGTH, 64'd31));
    for (int i = 0; i < MAX_PATTERN - 1; i++)
      directed_rows.push_back(beat_row(8'hFF, 0, 0, 0, 64'd0));
    directed_rows.push_back(beat_row(8'hFF, 1, 1, 1, 64'd0));
    // A match that would need the byte after the last one is not found.
    directed_rows.push_back(wr_row(REG_PATTERN_LENGTH, 64'd2));
    directed_rows.push_back(wr_row(REG_PATTERN_LOW, 64'hCDAB));
    directed_rows.push_back(wr_row(REG_COMPARE_MASK, 64'h3));
    directed_rows.push_back(beat_row(8'h12, 0, 0, 0, 64'd0));
    directed_rows.push_back(beat_row(8'hAB, 1, 1, 0, 64'd0));
    // All wildcards, but no start offset is allowed.
    directed_rows.push_back(wr_row(REG_SEARCH_LENGTH, 64'd0));
    directed_rows.push_back(wr_row(REG_COMPARE_MASK, 64'h0));
    directed_rows.push_back(wr_row(REG_PATTERN_LENGTH, 64'd3));
    directed_rows.push_back(beat_row(8'h00, 0, 0, 0, 64'd0));
    directed_rows.push_back(beat_row(8'h00, 0, 0, 0, 64'd0));
    directed_rows.push_back(beat_row(8'h00, 1, 1, 0, 64'd0));
    // The match starts exactly at the search length and does not count.
    directed_rows.push_back(wr_row(REG_SEARCH_LENGTH, 64'd1));
    directed_rows.push_back(wr_row(REG_COMPARE_MASK, 64'h1));
    directed_rows.push_back(wr_row(REG_PATTERN_LENGTH, 64'd1));
    directed_rows.push_back(wr_row(REG_PATTERN_LOW, 64'd0));
    directed_rows.push_back(beat_row(8'h11, 0, 0, 0, 64'd0));
    directed_rows.push_back(beat_row(8'h00, 1, 1, 0, 64'd0));

    // Walk the table; writes only go out once the block has gone quiet.
    cfg_open = 0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        if (!cfg_open) wait_idle();
        write_reg(directed_rows[i].index, directed_rows[i].value);
        cfg_open = 1;
      end else begin
        if (cfg_open) begin
          cfg_done();
          cfg_open = 0;
        end
        send_beat(directed_rows[i].data, directed_rows[i].last, 1,
                  directed_rows[i].exp_n, directed_rows[i].exp, 1'b0);
      end
    end
    if (cfg_open) cfg_done();

    // Random scans, most with the pattern planted somewhere inside.
    first = 1;
    while (random_beats < RANDOM_ITEMS) begin
      if (first || $urandom_range(0, 99) < 35) begin
        wait_idle();
        pick_settings(first);
        cfg_done();
        first = 0;
      end
      calm      = ($urandom_range(0, 6) == 0);
      eff       = (cur_len > MAX_PATTERN) ? MAX_PATTERN : int'(cur_len);
      pat_all   = {cur_pat_hi, cur_pat_lo};
      n         = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24)
                                               : $urandom_range(25, 60);
      embed     = ($urandom_range(0, 99) < 75) && (eff > 0);
      fill_mode = $urandom_range(0, 1);
      if (embed && n < eff) n = eff + $urandom_range(0, 4);

      // Filler is either free bytes or bytes borrowed from the pattern.
      for (int k = 0; k < n; k++) begin
        if (fill_mode && eff > 0 && $urandom_range(0, 1)) begin
          pick          = $urandom_range(0, eff - 1);
          scan_bytes[k] = pat_all[8*pick +: 8];
        end else begin
          scan_bytes[k] = 8'($urandom);
        end
      end

      // Plant the pattern; some runs off the end, some get one bit spoiled.
      if (embed) begin
        r = $urandom_range(0, 99);
        p = (r < 15) ? $urandom_range(0, n - 1) : $urandom_range(0, n - eff);
        for (int k = 0; k < eff; k++)
          if (p + k < n && cur_mask[k]) scan_bytes[p + k] = pat_all[8*k +: 8];
        if (r >= 15 && r < 35) begin
          flip = $urandom_range(0, eff - 1);
          if (p + flip < n) scan_bytes[p + flip] ^= 8'(1 << $urandom_range(0, 7));
        end
      end

      // Now and then the registers change in the middle of a scan.
      mid_at = ($urandom_range(0, 99) < 5) ? $urandom_range(0, n - 1) : -1;
      for (int k = 0; k < n; k++) begin
        if (k == mid_at) begin
          wait_idle();
          pick_settings(0);
          cfg_done();
        end
        send_beat(scan_bytes[k], k == n - 1, 0, 0, '0, calm);
        random_beats++;
      end
    end

    // Let the last results drain, then watch for stray beats a while longer.
    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/mbps_pkg.sv
hdl/mbps_if.sv
hdl/mbps_cell.sv
hdl/mbps_result_queue.sv
hdl/masked_byte_pattern_search.sv
tb/tb_masked_byte_pattern_search.sv
